// ----- design/rlm_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rlm_pkg: shared types, codes and helpers for the RSA letter mod-exp core
// Command and register codes, controller state type, the command/status
// structs between controller and datapath, and letter decoding.
// ============================================================================
package rlm_pkg;

    // Widths and defaults
    localparam int MOD_WIDTH_DEF = 16;
    localparam int REG_WIDTH     = 16;
    // Headroom bits above the modulus width for acc * 26 + letter
    localparam int PACK_PAD      = 5;

    // Input commands
    localparam logic [1:0] CMD_APPEND   = 2'd0;
    localparam logic [1:0] CMD_ENCRYPT  = 2'd1;
    localparam logic [1:0] CMD_DECRYPT  = 2'd2;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_MODULUS  = 2'd0;
    localparam logic [1:0] REG_PUB_EXP  = 2'd1;
    localparam logic [1:0] REG_PRIV_EXP = 2'd2;

    // Configuration reset values
    localparam logic [REG_WIDTH-1:0] MODULUS_RESET  = 16'd323;
    localparam logic [REG_WIDTH-1:0] PUB_EXP_RESET  = 16'd5;
    localparam logic [REG_WIDTH-1:0] PRIV_EXP_RESET = 16'd173;

    // Character decoding
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [4:0] RADIX        = 5'd26;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_REDUCE_END,
        ST_EXP_CHECK,
        ST_EXP_STEP,
        ST_EXP_UPDATE,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;      // latch the input beat and load the reduction
        logic step;         // advance the serial mod units one bit
        logic mode_reduce;  // serial unit B shifts in raw bits
        logic reduce_end;   // take the reduced base
        logic exp_load;     // load both units for one exponent bit
        logic exp_update;   // take products, shift exponent
        logic out_load;     // write the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_cmd_used;  // input command is not reserved
        logic cnt_last;     // last serial step
        logic append_only;  // current command only appends
        logic exp_zero;     // no exponent bits left
        logic out_free;     // output register can take a result
    } dp_status_t;

    function automatic logic is_letter(input logic [7:0] ch);
        logic upper;
        logic lower;
        upper = (ch >= CHAR_UPPER_A) && (ch <= CHAR_UPPER_Z);
        lower = (ch >= CHAR_LOWER_A) && (ch <= CHAR_LOWER_Z);
        return upper || lower;
    endfunction

    function automatic logic [4:0] letter_index(input logic [7:0] ch);
        logic [7:0] diff;
        if (ch <= CHAR_UPPER_Z) begin
            diff = ch - CHAR_UPPER_A;
        end else begin
            diff = ch - CHAR_LOWER_A;
        end
        return diff[4:0];
    endfunction

endpackage

// ----- design/rlm_modstep.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rlm_modstep: bit-serial modular multiply / reduce unit
// Each step computes p = (2p + addend) mod m, the addend being the operand
// (multiply mode, when the next multiplier bit is set) or the bit itself
// (reduce mode). p and the operand stay below m, so two subtracts suffice.
// ============================================================================
module rlm_modstep #(
    parameter int DW = 16,
    parameter int XW = 21
) (
    input  logic          aclk,
    input  logic          load,
    input  logic          step,
    input  logic          mode_reduce,
    input  logic [XW-1:0] shift_init,
    input  logic [DW-1:0] operand,
    input  logic [DW-1:0] modulus,
    output logic [DW-1:0] prod
);

    logic [DW-1:0] p_reg, p_next;
    logic [XW-1:0] sh_reg, sh_next;
    logic [DW+1:0] m_ext, addend, t0, t1, t2;

    // One shift-add-reduce step
    always_comb begin
        m_ext = {2'b00, modulus};
        if (mode_reduce) begin
            addend = {{(DW+1){1'b0}}, sh_reg[XW-1]};
        end else begin
            addend = sh_reg[XW-1] ? {2'b00, operand} : '0;
        end
        t0 = {1'b0, p_reg, 1'b0} + addend;
        t1 = (t0 >= m_ext) ? (t0 - m_ext) : t0;
        t2 = (t1 >= m_ext) ? (t1 - m_ext) : t1;
    end

    // Load, advance or hold
    always_comb begin
        p_next  = p_reg;
        sh_next = sh_reg;
        if (load) begin
            p_next  = '0;
            sh_next = shift_init;
        end else if (step) begin
            p_next  = t2[DW-1:0];
            sh_next = {sh_reg[XW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        p_reg  <= p_next;
        sh_reg <= sh_next;
    end

    assign prod = p_reg;

endmodule

// ----- design/rlm_datapath.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rlm_datapath: registers, accumulator and serial mod units
// Holds configuration, the packed-letter accumulator, base / result /
// exponent registers, the step counter, two serial mod units and the
// output register.
// ============================================================================
module rlm_datapath #(
    parameter int MOD_WIDTH = rlm_pkg::MOD_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [rlm_pkg::REG_WIDTH-1:0]  cfg_data,
    // input beat fields
    input  logic [1:0]                     in_cmd,
    input  logic [7:0]                     in_char,
    input  logic [rlm_pkg::REG_WIDTH-1:0]  in_value,
    // output register
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [rlm_pkg::REG_WIDTH-1:0]  out_result,
    output logic                           out_was_decrypt,
    // control
    input  rlm_pkg::dp_cmd_t               dp_cmd,
    output rlm_pkg::dp_status_t            dp_status
);

    localparam int RW = rlm_pkg::REG_WIDTH;
    localparam int DW = (MOD_WIDTH < RW) ? MOD_WIDTH : RW;
    localparam int XW = DW + rlm_pkg::PACK_PAD;
    localparam int CW = $clog2(XW + 1);

    logic [RW-1:0] mod_cfg_reg, pub_cfg_reg, priv_cfg_reg;
    logic [DW-1:0] acc_reg;
    logic          out_valid_reg;
    logic [1:0]    cmd_reg;
    logic          is_let_reg;
    logic [DW-1:0] m_reg, e_reg, r_reg, b_reg;
    logic [CW-1:0] cnt_reg;
    logic [RW-1:0] res_reg;
    logic          was_dec_reg;

    logic [DW-1:0] m_raw, m_eff;
    logic [XW-1:0] x_pack, x_src;
    logic [XW-1:0] init_a, init_b;
    logic [DW-1:0] prod_a, prod_b;
    logic          load_b;

    // Effective modulus: zero behaves as one
    assign m_raw = mod_cfg_reg[DW-1:0];
    assign m_eff = (m_raw == '0) ? DW'(1) : m_raw;

    // Value to reduce at capture
    always_comb begin
        x_pack = XW'(acc_reg) * XW'(rlm_pkg::RADIX)
               + XW'(rlm_pkg::letter_index(in_char));
        if (in_cmd == rlm_pkg::CMD_DECRYPT) begin
            x_src = XW'(in_value[DW-1:0]);
        end else if (rlm_pkg::is_letter(in_char)) begin
            x_src = x_pack;
        end else begin
            x_src = XW'(acc_reg);
        end
    end

    // Serial unit loads: A multiplies r by b, B reduces or squares b
    assign init_a = {r_reg, {rlm_pkg::PACK_PAD{1'b0}}};
    assign init_b = dp_cmd.capture ? x_src : {b_reg, {rlm_pkg::PACK_PAD{1'b0}}};
    assign load_b = dp_cmd.capture || dp_cmd.exp_load;

    rlm_modstep #(.DW(DW), .XW(XW)) u_mul_a (
        .aclk        (aclk),
        .load        (dp_cmd.exp_load),
        .step        (dp_cmd.step),
        .mode_reduce (1'b0),
        .shift_init  (init_a),
        .operand     (b_reg),
        .modulus     (m_reg),
        .prod        (prod_a)
    );

    rlm_modstep #(.DW(DW), .XW(XW)) u_mul_b (
        .aclk        (aclk),
        .load        (load_b),
        .step        (dp_cmd.step),
        .mode_reduce (dp_cmd.mode_reduce),
        .shift_init  (init_b),
        .operand     (b_reg),
        .modulus     (m_reg),
        .prod        (prod_b)
    );

    // Configuration, accumulator and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_cfg_reg   <= rlm_pkg::MODULUS_RESET;
            pub_cfg_reg   <= rlm_pkg::PUB_EXP_RESET;
            priv_cfg_reg  <= rlm_pkg::PRIV_EXP_RESET;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    rlm_pkg::REG_MODULUS:  mod_cfg_reg  <= cfg_data;
                    rlm_pkg::REG_PUB_EXP:  pub_cfg_reg  <= cfg_data;
                    rlm_pkg::REG_PRIV_EXP: priv_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
            // only a letter adds to the accumulator, an encrypt write clears it; other bytes leave it as is
            if (dp_cmd.reduce_end && is_let_reg && (cmd_reg != rlm_pkg::CMD_DECRYPT)) begin
                acc_reg <= prod_b;
            end else if (dp_cmd.out_load && (cmd_reg == rlm_pkg::CMD_ENCRYPT)) begin
                acc_reg <= '0;
            end
            if (dp_cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (dp_cmd.capture) begin
            cmd_reg    <= in_cmd;
            is_let_reg <= rlm_pkg::is_letter(in_char);
            m_reg      <= m_eff;
            e_reg      <= (in_cmd == rlm_pkg::CMD_DECRYPT) ? priv_cfg_reg[DW-1:0]
                                                           : pub_cfg_reg[DW-1:0];
        end else if (dp_cmd.exp_update) begin
            e_reg <= e_reg >> 1;
        end

        if (dp_cmd.capture) begin
            cnt_reg <= CW'(XW);
        end else if (dp_cmd.exp_load) begin
            cnt_reg <= CW'(DW);
        end else if (dp_cmd.step) begin
            cnt_reg <= cnt_reg - CW'(1);
        end

        if (dp_cmd.reduce_end) begin
            b_reg <= prod_b;
            r_reg <= (m_reg == DW'(1)) ? '0 : DW'(1);
        end else if (dp_cmd.exp_update) begin
            b_reg <= prod_b;
            if (e_reg[0]) begin
                r_reg <= prod_a;
            end
        end

        if (dp_cmd.out_load) begin
            res_reg     <= RW'(r_reg);
            was_dec_reg <= (cmd_reg == rlm_pkg::CMD_DECRYPT);
        end
    end

    // Status back to the controller
    always_comb begin
        dp_status.in_cmd_used = (in_cmd != rlm_pkg::CMD_RESERVED);
        dp_status.cnt_last    = (cnt_reg == CW'(1));
        dp_status.append_only = (cmd_reg == rlm_pkg::CMD_APPEND);
        dp_status.exp_zero    = (e_reg == '0);
        dp_status.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign out_result      = res_reg;
    assign out_was_decrypt = was_dec_reg;

endmodule

// ----- design/rlm_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rlm_ctrl: sequencer for the RSA letter mod-exp core
// Steps through capture, base reduction, one pass per exponent bit and the
// output write, issuing datapath commands from the current state.
// ============================================================================
module rlm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  rlm_pkg::dp_status_t dp_status,
    output rlm_pkg::dp_cmd_t    dp_cmd
);

    rlm_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rlm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rlm_pkg::ST_IDLE: begin
                if (in_valid && dp_status.in_cmd_used) begin
                    state_next = rlm_pkg::ST_REDUCE;
                end
            end
            rlm_pkg::ST_REDUCE: begin
                if (dp_status.cnt_last) begin
                    state_next = rlm_pkg::ST_REDUCE_END;
                end
            end
            rlm_pkg::ST_REDUCE_END: begin
                state_next = dp_status.append_only ? rlm_pkg::ST_IDLE
                                                   : rlm_pkg::ST_EXP_CHECK;
            end
            rlm_pkg::ST_EXP_CHECK: begin
                state_next = dp_status.exp_zero ? rlm_pkg::ST_DONE
                                                : rlm_pkg::ST_EXP_STEP;
            end
            rlm_pkg::ST_EXP_STEP: begin
                if (dp_status.cnt_last) begin
                    state_next = rlm_pkg::ST_EXP_UPDATE;
                end
            end
            rlm_pkg::ST_EXP_UPDATE: begin
                state_next = rlm_pkg::ST_EXP_CHECK;
            end
            rlm_pkg::ST_DONE: begin
                if (dp_status.out_free) begin
                    state_next = rlm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rlm_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb begin
        in_ready = 1'b0;
        dp_cmd   = '0;
        unique case (state_reg)
            rlm_pkg::ST_IDLE: begin
                in_ready       = 1'b1;
                dp_cmd.capture = in_valid;
            end
            rlm_pkg::ST_REDUCE: begin
                dp_cmd.step        = 1'b1;
                dp_cmd.mode_reduce = 1'b1;
            end
            rlm_pkg::ST_REDUCE_END: begin
                dp_cmd.reduce_end = 1'b1;
            end
            rlm_pkg::ST_EXP_CHECK: begin
                dp_cmd.exp_load = !dp_status.exp_zero;
            end
            rlm_pkg::ST_EXP_STEP: begin
                dp_cmd.step = 1'b1;
            end
            rlm_pkg::ST_EXP_UPDATE: begin
                dp_cmd.exp_update = 1'b1;
            end
            rlm_pkg::ST_DONE: begin
                dp_cmd.out_load = dp_status.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ----- design/rsa_letter_modexp_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rsa_letter_modexp_core: toy RSA engine with letter packing
// Packs letters base 26 into a modular accumulator, encrypts it on request
// and decrypts ciphertext values, all by serial square-and-multiply.
// ============================================================================
// Usage:
//   s_ beats carry a command in s_tuser and a character or ciphertext in
//   s_tdata. Append (0) packs a letter into the accumulator, encrypt (1)
//   appends and then returns acc^e mod n and clears the accumulator, decrypt
//   (2) returns value^d mod n. Command 3 is dropped.
//   m_ beats carry the result in m_tdata and a decrypt flag in m_tuser.
//   cfg_ writes set modulus, public and private exponent; write only while
//   the core is idle. cfg_ready is always high.
// Sequence (W = min(MOD_WIDTH,16)):
//   the base reduction shifts all W+5 packed bits through unit B; each
//   exponent bit then runs both serial mod units (r*b and b*b) side by
//   side one multiplier bit per cycle over W bits, then updates r and b.
//   An append returns to idle after the reduction. One item is in flight
//   at a time.
// Reset restores the register defaults (323, 5, 173) and clears the
// accumulator. A stalled m_ side holds the result register; a new beat is
// still taken, and its result waits until the held one is taken.
// ============================================================================
module rsa_letter_modexp_core #(
    parameter int MOD_WIDTH = rlm_pkg::MOD_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] char_code, [23:8] value
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] result
    output logic        m_tuser,   // [0] was_decrypt
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    rlm_pkg::dp_cmd_t    dp_cmd;
    rlm_pkg::dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    rlm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    rlm_datapath #(.MOD_WIDTH(MOD_WIDTH)) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_cmd          (s_tuser),
        .in_char         (s_tdata[7:0]),
        .in_value        (s_tdata[23:8]),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_result      (m_tdata),
        .out_was_decrypt (m_tuser),
        .dp_cmd          (dp_cmd),
        .dp_status       (dp_status)
    );

    // A dropped command leaves the core ready for the next beat
    a_reserved_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == rlm_pkg::CMD_RESERVED)) |=> s_tready)
        else $error("reserved command did not return to idle");

    // A result only appears from an output write
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(dp_cmd.out_load))
        else $error("result valid without output write");

    // Never overwrite a result that is still held
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while stalled");

    // No result can be ready the cycle after a beat is accepted
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!m_tvalid || $past(m_tvalid)))
        else $error("result appeared right after acceptance");

endmodule

// ----- verif/rsa_letter_modexp_core_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rsa_letter_modexp_core_tb: self-checking bench for the RSA letter engine
// Streams append, encrypt, decrypt and reserved commands through the core
// under several register settings. A built-in predictor tracks the letter
// accumulator and computes every mod-exp result for comparison against the
// m_ beats. Both stream sides idle at random, and the result side once holds
// off long enough to back the core up into its input.
// ============================================================================
module rsa_letter_modexp_core_tb;

    localparam logic [1:0] REG_UNUSED      = 2'd3;
    localparam int         WATCHDOG_LIMIT  = 10000;
    localparam int         HOLD_OFF_CYCLES = 1500;
    localparam int         DRAIN_CYCLES    = 400;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  ch;
        logic [15:0] value;
    } rsa_beat_t;

    typedef struct {
        logic [15:0] result;
        logic        was_decrypt;
    } rsa_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [7:0] char_code, [23:8] value
    logic [1:0]  s_tuser;   // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] result
    logic        m_tuser;   // [0] was_decrypt
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Stimulus and expectation stores
    rsa_beat_t   pending_beats[$];
    rsa_result_t expected_results[$];
    rsa_beat_t   cur_beat;

    // Predictor copy of the registers and the letter accumulator
    logic [15:0] cfg_mod;
    logic [15:0] cfg_pub;
    logic [15:0] cfg_priv;
    logic [15:0] letter_acc;

    int queued_count;
    int accepted_count;
    int err_count;
    int stall_cycles;
    int s_gap;
    int m_gap;
    int hold_left;
    bit s_beat;
    bit hold_req;
    bit idle_on;

    rsa_letter_modexp_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Square-and-multiply over all 16 exponent bits, base reduced first
    function automatic logic [15:0] mod_pow(input logic [15:0] base, input logic [15:0] ex,
                                            input longint unsigned m);
        longint unsigned r;
        longint unsigned b;
        r = 1 % m;
        b = base % m;
        for (int i = 0; i < 16; i++) begin
            if (ex[i]) begin
                r = (r * b) % m;
            end
            b = (b * b) % m;
        end
        return r[15:0];
    endfunction

    // Advance the accumulator for one accepted beat and queue its result
    task automatic predict_rsa_beat(input rsa_beat_t bt);
        longint unsigned m;
        logic [7:0]      letter;
        bit              is_alpha;
        rsa_result_t     res;
        m = (cfg_mod == 16'd0) ? 1 : cfg_mod;
        if (bt.cmd == rlm_pkg::CMD_APPEND || bt.cmd == rlm_pkg::CMD_ENCRYPT) begin
            is_alpha = 1'b1;
            letter = 8'd0;
            if (bt.ch >= rlm_pkg::CHAR_UPPER_A && bt.ch <= rlm_pkg::CHAR_UPPER_Z) begin
                letter = bt.ch - rlm_pkg::CHAR_UPPER_A;
            end else if (bt.ch >= rlm_pkg::CHAR_LOWER_A && bt.ch <= rlm_pkg::CHAR_LOWER_Z) begin
                letter = bt.ch - rlm_pkg::CHAR_LOWER_A;
            end else begin
                is_alpha = 1'b0;
            end
            if (is_alpha) begin
                letter_acc = 16'((longint'(letter_acc) * rlm_pkg::RADIX + letter) % m);
            end
            if (bt.cmd == rlm_pkg::CMD_ENCRYPT) begin
                res.result      = mod_pow(letter_acc, cfg_pub, m);
                res.was_decrypt = 1'b0;
                expected_results.push_back(res);
                letter_acc = 16'd0;
            end
        end else if (bt.cmd == rlm_pkg::CMD_DECRYPT) begin
            res.result      = mod_pow(bt.value, cfg_priv, m);
            res.was_decrypt = 1'b1;
            expected_results.push_back(res);
        end
    endtask

    function automatic int gap_len();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? rlm_pkg::CHAR_UPPER_A : rlm_pkg::CHAR_LOWER_A)
               + 8'($urandom_range(0, 25));
    endfunction

    task automatic push_beat(input logic [1:0] cmd, input logic [7:0] ch,
                             input logic [15:0] value);
        rsa_beat_t bt;
        bt.cmd   = cmd;
        bt.ch    = ch;
        bt.value = value;
        pending_beats.push_back(bt);
        queued_count++;
    endtask

    // Mostly words ended by an encrypt, plus decrypts; the rest is noise
    task automatic queue_random(input int n);
        int              made;
        int              sel;
        longint unsigned m;
        logic [7:0]      ch;
        made = 0;
        m = (cfg_mod == 16'd0) ? 1 : cfg_mod;
        while (made < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                repeat ($urandom_range(0, 6)) begin
                    push_beat(rlm_pkg::CMD_APPEND, rand_letter(), 16'($urandom));
                    made++;
                end
                ch = $urandom_range(0, 1) ? rand_letter() : 8'($urandom);
                push_beat(rlm_pkg::CMD_ENCRYPT, ch, 16'($urandom));
                made++;
            end else if (sel < 80) begin
                push_beat(rlm_pkg::CMD_DECRYPT, 8'($urandom),
                          $urandom_range(0, 1) ? 16'($urandom_range(0, m - 1)) : 16'($urandom));
                made++;
            end else if (sel < 92) begin
                push_beat(rlm_pkg::CMD_APPEND, 8'($urandom), 16'($urandom));
                made++;
            end else if (sel < 97) begin
                push_beat(rlm_pkg::CMD_ENCRYPT, 8'($urandom), 16'($urandom));
                made++;
            end else begin
                push_beat(rlm_pkg::CMD_RESERVED, 8'($urandom), 16'($urandom));
                made++;
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            rlm_pkg::REG_MODULUS:  cfg_mod  = data;
            rlm_pkg::REG_PUB_EXP:  cfg_pub  = data;
            rlm_pkg::REG_PRIV_EXP: cfg_priv = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] m, input logic [15:0] e, input logic [15:0] d);
        write_reg(rlm_pkg::REG_MODULUS, m);
        write_reg(rlm_pkg::REG_PUB_EXP, e);
        write_reg(rlm_pkg::REG_PRIV_EXP, d);
    endtask

    // Drain: all beats taken, all results back, then let a trailing append finish
    task automatic wait_idle();
        while (accepted_count != queued_count || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Input side: note each accepted beat and run the predictor on it
    always @(posedge aclk) begin
        s_beat = aresetn && s_tvalid && s_tready;
        if (s_beat) begin
            predict_rsa_beat(cur_beat);
            accepted_count++;
        end
    end

    // Input driver: hold a beat until taken, then gap or present the next one
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_beat) begin
            // hold the current beat
        end else if (s_gap > 0) begin
            s_gap--;
            s_tvalid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
            cur_beat = pending_beats.pop_front();
            s_tvalid <= 1'b1;
            s_tuser  <= cur_beat.cmd;
            s_tdata  <= {cur_beat.value, cur_beat.ch};
            s_gap = gap_len();
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Result side ready: one long hold-off on request, random stalls otherwise
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_req = 1'b0;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (m_gap > 0) begin
            m_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            m_gap = gap_len();
        end
    end

    // Result monitor: compare each beat against the oldest expectation
    always @(posedge aclk) begin : result_check
        rsa_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual result %0d flag %0b",
                         $time, m_tdata, m_tuser);
                err_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata !== want.result) begin
                    $display("%0t: result mismatch: expected %0d, actual %0d",
                             $time, want.result, m_tdata);
                    err_count++;
                end
                if (m_tuser !== want.was_decrypt) begin
                    $display("%0t: was_decrypt mismatch: expected %0b, actual %0b",
                             $time, want.was_decrypt, m_tuser);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_on   = 1'b1;
        cfg_mod   = rlm_pkg::MODULUS_RESET;
        cfg_pub   = rlm_pkg::PUB_EXP_RESET;
        cfg_priv  = rlm_pkg::PRIV_EXP_RESET;
        letter_acc = 16'd0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: letter bounds, neighbors of the letter ranges, every command
        push_beat(rlm_pkg::CMD_APPEND, rlm_pkg::CHAR_LOWER_A, 16'h0000);
        push_beat(rlm_pkg::CMD_APPEND, rlm_pkg::CHAR_UPPER_Z, 16'hFFFF);
        push_beat(rlm_pkg::CMD_APPEND, rlm_pkg::CHAR_LOWER_Z, 16'h0000);
        push_beat(rlm_pkg::CMD_APPEND, 8'h00, 16'hFFFF);
        push_beat(rlm_pkg::CMD_APPEND, 8'hFF, 16'h0000);
        push_beat(rlm_pkg::CMD_APPEND, rlm_pkg::CHAR_UPPER_A - 8'd1, 16'h1234);
        push_beat(rlm_pkg::CMD_APPEND, rlm_pkg::CHAR_UPPER_Z + 8'd1, 16'h4321);
        push_beat(rlm_pkg::CMD_APPEND, rlm_pkg::CHAR_LOWER_A - 8'd1, 16'h8000);
        push_beat(rlm_pkg::CMD_APPEND, rlm_pkg::CHAR_LOWER_Z + 8'd1, 16'h0001);
        push_beat(rlm_pkg::CMD_ENCRYPT, rlm_pkg::CHAR_UPPER_A, 16'h0000);
        // encrypt of an empty accumulator with a non-letter byte
        push_beat(rlm_pkg::CMD_ENCRYPT, 8'h20, 16'hFFFF);
        push_beat(rlm_pkg::CMD_APPEND, rlm_pkg::CHAR_UPPER_A + 8'd12, 16'h0000);
        push_beat(rlm_pkg::CMD_APPEND, rlm_pkg::CHAR_LOWER_A + 8'd7, 16'h0000);
        push_beat(rlm_pkg::CMD_ENCRYPT, 8'h21, 16'h0000);
        push_beat(rlm_pkg::CMD_DECRYPT, 8'h00, 16'd0);
        // ciphertext at and above the modulus
        push_beat(rlm_pkg::CMD_DECRYPT, 8'hFF, 16'hFFFF);
        push_beat(rlm_pkg::CMD_DECRYPT, 8'h00, rlm_pkg::MODULUS_RESET);
        push_beat(rlm_pkg::CMD_DECRYPT, 8'h00, rlm_pkg::MODULUS_RESET - 16'd1);
        // reserved command: dropped without touching the accumulator
        push_beat(rlm_pkg::CMD_APPEND, rlm_pkg::CHAR_LOWER_A + 8'd3, 16'h0000);
        push_beat(rlm_pkg::CMD_RESERVED, rlm_pkg::CHAR_LOWER_A, 16'hAAAA);
        push_beat(rlm_pkg::CMD_RESERVED, 8'hFF, 16'hFFFF);
        push_beat(rlm_pkg::CMD_ENCRYPT, rlm_pkg::CHAR_LOWER_Z, 16'h5555);

        queue_random(280);
        // back the core up once traffic is flowing
        while (accepted_count < 40) @(posedge aclk);
        hold_req = 1'b1;
        wait_idle();

        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_random(150);
        wait_idle();

        // zero public exponent on the smallest legal modulus
        write_reg(REG_UNUSED, 16'hFFFF);
        set_config(16'd2, 16'd0, 16'd1);
        queue_random(100);
        wait_idle();

        // modulus zero behaves as modulus one
        set_config(16'd0, 16'd3, 16'd7);
        queue_random(80);
        wait_idle();

        set_config(16'd1, 16'hFFFF, 16'd0);
        queue_random(80);
        wait_idle();

        // a stretch with no idling on either side
        idle_on = 1'b0;
        set_config(16'd33, 16'd3, 16'd7);
        queue_random(150);
        wait_idle();
        idle_on = 1'b1;

        repeat (3) begin
            set_config(16'($urandom_range(2, 65535)), 16'($urandom), 16'($urandom));
            queue_random(100);
            wait_idle();
        end

        set_config(16'($urandom_range(2, 65535)), 16'd0, 16'd0);
        queue_random(60);
        wait_idle();

        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/rlm_pkg.sv
design/rlm_modstep.sv
design/rlm_datapath.sv
design/rlm_ctrl.sv
design/rsa_letter_modexp_core.sv
verif/rsa_letter_modexp_core_tb.sv
